[hdl/mhtf_pkg.sv]
// ----------------------------------------------------------------------------
// mhtf_pkg
// Shared types and constants for the MAC address hash table unit: controller
// states, opcodes, result status codes, step limits and FNV-1a hash constants.
// ----------------------------------------------------------------------------
package mhtf_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_HEAD,
      ST_LINK,
      ST_WALK
   } state_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [2:0] LAST_BYTE  = 3'd5;
   localparam logic [2:0] LAST_CHUNK = 3'd3;

endpackage

[hdl/mac_hash_table_fnv1a_unit.sv]
// ----------------------------------------------------------------------------
// mac_hash_table_fnv1a_unit
// Chained hash table of station addresses. The bucket is the 32-bit FNV-1a
// hash of the six address bytes modulo BUCKETS. Inserts link a new pool entry
// at the head of its chain; lookups walk the chain and report the newest match.
//
//   channel   ports                         beat taken when
//   request   start, busy, req_*            start && !busy
//   response  rsp_valid, rsp_*              rsp_valid (one cycle, no stall)
//
// Busy stays high while an item passes the hash, modulo, head-read and link
// states and, for a lookup, one walk step per chain entry it compares.
// The response shows in the cycle after the last busy one, with busy low; a new
// request can be taken in that same cycle. After reset, busy stays high while
// all bucket heads are cleared. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module mac_hash_table_fnv1a_unit #(
   parameter int BUCKETS = 64,
   parameter int ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [47:0]            req_mac,
   input  logic [7:0]             req_ap_id,
   input  logic signed [7:0]      req_rssi,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_found_ap_id,
   output logic signed [7:0]      rsp_found_rssi,
   output logic [8:0]             rsp_entries_used
);
   import mhtf_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW = $clog2(ENTRIES + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);
   localparam logic [BW:0] BUCKET_COUNT = (BW + 1)'(BUCKETS);
   localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

   typedef struct packed {
      logic [47:0]   mac;
      logic [7:0]    ap;
      logic [7:0]    sig;
      logic [LW-1:0] link;
   } entry_type;

   logic [LW-1:0] head_mem [BUCKETS];
   entry_type     ent_mem  [ENTRIES];

   state_type     state_ff, state_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic          op_ff, op_in;
   logic [47:0]   mac_ff, mac_in;
   logic [7:0]    ap_ff, ap_in;
   logic [7:0]    sig_ff, sig_in;
   logic [31:0]   hash_ff, hash_in;
   logic [2:0]    step_ff, step_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] walk_ff, walk_in;
   logic [LW-1:0] head_rd_ff;
   entry_type     ent_rd_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_ap_ff, rsp_ap_in;
   logic [7:0]    rsp_sig_ff, rsp_sig_in;
   logic [8:0]    rsp_used_ff, rsp_used_in;

   logic          head_we;
   logic [BW-1:0] head_wa;
   logic [LW-1:0] head_wd;
   logic          ent_we;
   entry_type     ent_wd;
   logic          ent_re;
   logic [IW-1:0] ent_ra;

   logic [31:0]   hash_mix;
   logic [BW-1:0] rem_mod;
   logic [LW-1:0] walk_next;
   logic          ent_match;
   logic          walk_end;
   logic          pool_full;

   assign hash_mix  = hash_ff ^ {24'd0, mac_ff[47:40]};
   assign walk_next = walk_ff + LW'(1);
   assign ent_match = (ent_rd_ff.mac == mac_ff);
   assign walk_end  = (ent_rd_ff.link >= NULL_LINK) || (walk_next >= NULL_LINK);
   assign pool_full = (count_ff >= NULL_LINK);

   always_comb begin
      logic [BW:0] acc;
      acc = {1'b0, rem_ff};
      for (int i = 0; i < 8; i++) begin
         acc = {acc[BW-1:0], hash_ff[31-i]};
         if (acc >= BUCKET_COUNT) begin
            acc = acc - BUCKET_COUNT;
         end
      end
      rem_mod = acc[BW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_BUCKET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (step_ff == LAST_BYTE) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (step_ff == LAST_CHUNK) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = ST_LINK;
         end
         ST_LINK: begin
            if (op_ff == OP_INSERT || head_rd_ff >= NULL_LINK) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (ent_match || walk_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      clr_in        = clr_ff;
      op_in         = op_ff;
      mac_in        = mac_ff;
      ap_in         = ap_ff;
      sig_in        = sig_ff;
      hash_in       = hash_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      head_we       = 1'b0;
      head_wa       = rem_ff;
      head_wd       = count_ff;
      ent_we        = 1'b0;
      ent_wd        = '{mac: mac_ff, ap: ap_ff, sig: sig_ff, link: head_rd_ff};
      ent_re        = 1'b0;
      ent_ra        = head_rd_ff[IW-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_ap_in     = 8'd0;
      rsp_sig_in    = 8'd0;
      unique case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = NULL_LINK;
            clr_in  = clr_ff + BW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               op_in   = req_operation;
               mac_in  = req_mac;
               ap_in   = req_ap_id;
               sig_in  = req_rssi;
               hash_in = FNV_BASIS;
               step_in = 3'd0;
            end
         end
         ST_HASH: begin
            // Six byte rotations bring the address back to its original order.
            hash_in = hash_mix * FNV_PRIME;
            mac_in  = {mac_ff[39:0], mac_ff[47:40]};
            step_in = step_ff + 3'd1;
            if (step_ff == LAST_BYTE) begin
               step_in = 3'd0;
               rem_in  = '0;
            end
         end
         ST_MOD: begin
            hash_in = {hash_ff[23:0], 8'd0};
            rem_in  = rem_mod;
            step_in = step_ff + 3'd1;
         end
         ST_HEAD: begin
         end
         ST_LINK: begin
            if (op_ff == OP_INSERT) begin
               rsp_valid_in = 1'b1;
               if (pool_full) begin
                  rsp_status_in = STATUS_REFUSED;
               end else begin
                  ent_we   = 1'b1;
                  head_we  = 1'b1;
                  count_in = count_ff + LW'(1);
               end
            end else if (head_rd_ff >= NULL_LINK) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_MISS;
            end else begin
               ent_re  = 1'b1;
               walk_in = '0;
            end
         end
         ST_WALK: begin
            if (ent_match) begin
               rsp_valid_in = 1'b1;
               rsp_ap_in    = ent_rd_ff.ap;
               rsp_sig_in   = ent_rd_ff.sig;
            end else if (walk_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_MISS;
            end else begin
               ent_re  = 1'b1;
               ent_ra  = ent_rd_ff.link[IW-1:0];
               walk_in = walk_next;
            end
         end
         default: begin
         end
      endcase
      rsp_used_in = 9'(count_in);
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (state_ff == ST_HEAD) begin
         head_rd_ff <= head_mem[rem_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[count_ff[IW-1:0]] <= ent_wd;
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[ent_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= 3'd0;
         count_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      mac_ff  <= mac_in;
      ap_ff   <= ap_in;
      sig_ff  <= sig_in;
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_ap_ff     <= rsp_ap_in;
         rsp_sig_ff    <= rsp_sig_in;
         rsp_used_ff   <= rsp_used_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_ap_id  = rsp_ap_ff;
   assign rsp_found_rssi   = rsp_sig_ff;
   assign rsp_entries_used = rsp_used_ff;

endmodule
